// ===== src/ecsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecsr_pkg
// Shared types and codes for the edge list to compressed-row builder.
// ----------------------------------------------------------------------------
package ecsr_pkg;

	localparam int NCW = 11;

	localparam logic [2:0] FUNC_CLEAR = 3'd0;
	localparam logic [2:0] FUNC_ADD   = 3'd1;
	localparam logic [2:0] FUNC_BUILD = 3'd2;
	localparam logic [2:0] FUNC_RROW  = 3'd3;
	localparam logic [2:0] FUNC_RCOL  = 3'd4;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_RANGE = 3'd1;
	localparam logic [2:0] ST_SELF  = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_BAD   = 3'd4;
	localparam logic [2:0] ST_NOTB  = 3'd5;

	localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

	typedef struct packed {
		logic        [2:0]  func;
		logic signed [31:0] node_a;
		logic signed [31:0] node_b;
		logic        [12:0] read_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [13:0] value;
		logic [12:0] legal_edges;
		logic [15:0] offered_edges;
	} rsp_t;

	typedef struct packed {
		logic [NCW-1:0] node_count;
		logic           wr;
	} cfg_t;

endpackage

// ===== src/ecsr_alu.sv =====
// ----------------------------------------------------------------------------
// ecsr_alu
// Shared adder used for degree updates, prefix sums and fill pointers.
// ----------------------------------------------------------------------------
module ecsr_alu #(
	parameter int W = 14
) (
	input  logic [W-1:0] op_a,
	input  logic [W-1:0] op_b,
	output logic [W-1:0] sum
);
	assign sum = op_a + op_b;
endmodule

// ===== src/ecsr_apb.sv =====
// ----------------------------------------------------------------------------
// ecsr_apb
// Configuration register block holding node_count.
// ----------------------------------------------------------------------------
module ecsr_apb (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output ecsr_pkg::cfg_t        cfg
);
	import ecsr_pkg::*;

	logic [NCW-1:0] node_count_q;
	logic           hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == ADDR_NODE_COUNT[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCW'(1024);
		end else if (psel && penable && pwrite && hit) begin
			node_count_q <= pwdata[NCW-1:0];
		end
	end

	assign prdata = hit ? {{(32-NCW){1'b0}}, node_count_q} : 32'd0;
	assign cfg.node_count = node_count_q;
	assign cfg.wr = psel && penable && pwrite && hit;
endmodule

// ===== src/edge_list_to_csr_builder.sv =====
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder
// Symmetric compressed-row adjacency builder from an undirected edge list.
// ----------------------------------------------------------------------------
//  channel | signals                          | role
//  cmd     | cmd_valid, cmd_ready, cmd        | item in (clear/add/build/read)
//  rsp     | rsp_valid, rsp_ready, rsp        | one result item per command
//  apb     | psel..pready                     | node_count register
//
//  Add edge: degree read-modify-write of both ends on one port (S_ADD0..S_ADD2).
//  Build: prefix walk over the nodes, then edge scatter over the stored edges.
//  Clear: one degree entry zeroed per cycle.
//  Reset runs the same degree sweep with cmd_ready low.
//  Reads: range check, memory read, then result. A held result stalls only the next item's final step.
// ----------------------------------------------------------------------------
module edge_list_to_csr_builder #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ecsr_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ecsr_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import ecsr_pkg::*;

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int RW = $clog2(MAX_NODES + 1);
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int LW = $clog2(MAX_EDGES + 1);
	localparam int XW = $clog2(2 * MAX_EDGES);
	localparam int PW = $clog2(2 * MAX_EDGES + 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ADD0 = 4'd2;
	localparam logic [3:0] S_ADD1 = 4'd3;
	localparam logic [3:0] S_ADD2 = 4'd4;
	localparam logic [3:0] S_B0   = 4'd5;
	localparam logic [3:0] S_P0   = 4'd6;
	localparam logic [3:0] S_P1   = 4'd7;
	localparam logic [3:0] S_E0   = 4'd8;
	localparam logic [3:0] S_E1   = 4'd9;
	localparam logic [3:0] S_E2   = 4'd10;
	localparam logic [3:0] S_E3   = 4'd11;
	localparam logic [3:0] S_RD0  = 4'd12;
	localparam logic [3:0] S_RD1  = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	cfg_t cfg;

	ecsr_apb u_apb (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	logic [3:0]  state_q;
	logic [AW-1:0] clr_q;
	logic        pend_q;
	logic [2:0]  func_q;
	logic [31:0] a_q, b_q;
	logic [12:0] idx_q;
	logic [LW-1:0] legal_q;
	logic [15:0] offered_q;
	logic        built_q;
	logic [NW-1:0] i_q;
	logic [PW-1:0] acc_q, rsn_q;
	logic [LW-1:0] e_q;
	logic [AW-1:0] ea_q, eb_q;
	logic [2:0]  res_st_q;
	logic [13:0] res_val_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic [PW-1:0] deg_mem [MAX_NODES];
	logic [PW-1:0] rs_mem [MAX_NODES+1];
	logic [2*AW-1:0] es_mem [MAX_EDGES];
	logic [PW-1:0] fill_mem [MAX_NODES];
	logic [AW-1:0] nb_mem [2*MAX_EDGES];

	logic deg_we, rs_we, es_we, fill_we, nb_we;
	logic [AW-1:0] deg_wa, deg_ra, fill_wa, fill_ra;
	logic [PW-1:0] deg_wd, rs_wd, fill_wd;
	logic [RW-1:0] rs_wa, rs_ra;
	logic [EW-1:0] es_wa, es_ra;
	logic [2*AW-1:0] es_wd;
	logic [XW-1:0] nb_wa, nb_ra;
	logic [AW-1:0] nb_wd;
	logic [PW-1:0] deg_rd_q, rs_rd_q, fill_rd_q;
	logic [2*AW-1:0] es_rd_q;
	logic [AW-1:0] nb_rd_q;

	logic [PW-1:0] alu_a, alu_b, alu_sum;
	logic [NW-1:0] n_eff;
	logic          accept, a_out, b_out, fill_ok, take;

	ecsr_alu #(.W(PW)) u_alu (.op_a(alu_a), .op_b(alu_b), .sum(alu_sum));

	assign n_eff = ({{(32-NCW){1'b0}}, cfg.node_count} > 32'(MAX_NODES))
		? NW'(MAX_NODES) : NW'(cfg.node_count);
	assign a_out = a_q >= 32'(n_eff);
	assign b_out = b_q >= 32'(n_eff);
	assign fill_ok = 32'(fill_rd_q) < 32'(2 * MAX_EDGES);
	assign cmd_ready = (state_q == S_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign take = !rsp_valid_q || rsp_ready;

	always_comb begin
		alu_a = fill_rd_q;
		alu_b = PW'(1);
		unique case (state_q)
			S_ADD1, S_ADD2: alu_a = deg_rd_q;
			S_P1: begin
				alu_a = acc_q;
				alu_b = deg_rd_q;
			end
			default: alu_a = fill_rd_q;
		endcase
	end

	always_comb begin
		deg_we = 1'b0; deg_wa = clr_q; deg_wd = '0; deg_ra = a_q[AW-1:0];
		rs_we = 1'b0; rs_wa = '0; rs_wd = '0; rs_ra = RW'(idx_q);
		es_we = 1'b0; es_wa = legal_q[EW-1:0]; es_wd = {a_q[AW-1:0], b_q[AW-1:0]};
		es_ra = e_q[EW-1:0];
		fill_we = 1'b0; fill_wa = ea_q; fill_wd = alu_sum; fill_ra = es_rd_q[2*AW-1:AW];
		nb_we = 1'b0; nb_wa = fill_rd_q[XW-1:0]; nb_wd = eb_q; nb_ra = XW'(idx_q);
		unique case (state_q)
			S_CLR: deg_we = 1'b1;
			S_ADD0: es_we = !a_out && !b_out && (a_q != b_q) && (32'(legal_q) < 32'(MAX_EDGES));
			S_ADD1: begin
				deg_we = 1'b1; deg_wa = a_q[AW-1:0]; deg_wd = alu_sum;
				deg_ra = b_q[AW-1:0];
			end
			S_ADD2: begin
				deg_we = 1'b1; deg_wa = b_q[AW-1:0]; deg_wd = alu_sum;
			end
			S_B0: rs_we = 1'b1;
			S_P0: deg_ra = i_q[AW-1:0];
			S_P1: begin
				rs_we = 1'b1; rs_wa = RW'(i_q + NW'(1)); rs_wd = alu_sum;
				fill_we = 1'b1; fill_wa = i_q[AW-1:0]; fill_wd = acc_q;
			end
			S_E2: begin
				fill_we = (32'(ea_q) < 32'(n_eff)) && fill_ok;
				nb_we = fill_we;
				fill_ra = eb_q;
			end
			S_E3: begin
				fill_we = (32'(eb_q) < 32'(n_eff)) && fill_ok;
				fill_wa = eb_q;
				nb_we = fill_we; nb_wd = ea_q;
			end
			default: deg_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		if (rs_we) rs_mem[rs_wa] <= rs_wd;
		if (es_we) es_mem[es_wa] <= es_wd;
		if (fill_we) fill_mem[fill_wa] <= fill_wd;
		if (nb_we) nb_mem[nb_wa] <= nb_wd;
		deg_rd_q <= deg_mem[deg_ra];
		rs_rd_q <= rs_mem[rs_ra];
		es_rd_q <= es_mem[es_ra];
		fill_rd_q <= fill_mem[fill_ra];
		nb_rd_q <= nb_mem[nb_ra];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			a_q <= cmd.node_a;
			b_q <= cmd.node_b;
			idx_q <= cmd.read_index;
		end
		if (state_q == S_E1) begin
			ea_q <= es_rd_q[2*AW-1:AW];
			eb_q <= es_rd_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			pend_q <= 1'b0;
			legal_q <= '0;
			offered_q <= '0;
			built_q <= 1'b0;
			i_q <= '0;
			acc_q <= '0;
			rsn_q <= '0;
			e_q <= '0;
			res_st_q <= ST_OK;
			res_val_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			if (cfg.wr) built_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_NODES - 1)) begin
						clr_q <= '0;
						res_st_q <= ST_OK;
						res_val_q <= '0;
						state_q <= pend_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.func)
							FUNC_CLEAR: begin
								legal_q <= '0;
								offered_q <= '0;
								built_q <= 1'b0;
								pend_q <= 1'b1;
								state_q <= S_CLR;
							end
							FUNC_ADD: state_q <= S_ADD0;
							FUNC_BUILD: state_q <= S_B0;
							FUNC_RROW, FUNC_RCOL: state_q <= S_RD0;
							default: begin
								res_st_q <= ST_OK;
								res_val_q <= '0;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_ADD0: begin
					if (offered_q != 16'hFFFF) offered_q <= offered_q + 16'd1;
					res_val_q <= '0;
					if (a_out || b_out) begin
						res_st_q <= ST_RANGE;
						state_q <= S_OUT;
					end else if (a_q == b_q) begin
						res_st_q <= ST_SELF;
						state_q <= S_OUT;
					end else if (32'(legal_q) >= 32'(MAX_EDGES)) begin
						res_st_q <= ST_FULL;
						state_q <= S_OUT;
					end else begin
						state_q <= S_ADD1;
					end
				end
				S_ADD1: state_q <= S_ADD2;
				S_ADD2: begin
					legal_q <= legal_q + LW'(1);
					built_q <= 1'b0;
					res_st_q <= ST_OK;
					state_q <= S_OUT;
				end
				S_B0: begin
					acc_q <= '0;
					i_q <= '0;
					e_q <= '0;
					rsn_q <= '0;
					state_q <= (n_eff == '0) ? S_E0 : S_P0;
				end
				S_P0: state_q <= S_P1;
				S_P1: begin
					acc_q <= alu_sum;
					i_q <= i_q + NW'(1);
					if (i_q + NW'(1) == n_eff) begin
						rsn_q <= alu_sum;
						state_q <= S_E0;
					end else begin
						state_q <= S_P0;
					end
				end
				S_E0: begin
					if (e_q == legal_q) begin
						built_q <= 1'b1;
						res_st_q <= ST_OK;
						res_val_q <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_E1;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: state_q <= S_E3;
				S_E3: begin
					e_q <= e_q + LW'(1);
					state_q <= S_E0;
				end
				S_RD0: begin
					res_val_q <= '0;
					state_q <= S_OUT;
					if (!built_q) begin
						res_st_q <= ST_NOTB;
					end else if (func_q == FUNC_RROW) begin
						if (32'(idx_q) > 32'(n_eff)) res_st_q <= ST_BAD;
						else begin
							res_st_q <= ST_OK;
							state_q <= S_RD1;
						end
					end else if ((32'(idx_q) >= 32'(rsn_q)) ||
						(32'(idx_q) >= 32'(2 * MAX_EDGES))) begin
						res_st_q <= ST_BAD;
					end else begin
						res_st_q <= ST_OK;
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					res_val_q <= (func_q == FUNC_RROW) ? 14'(rs_rd_q) : 14'(nb_rd_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (take) begin
						rsp_q.status <= res_st_q;
						rsp_q.value <= res_val_q;
						rsp_q.legal_edges <= 13'(legal_q);
						rsp_q.offered_edges <= offered_q;
						rsp_valid_q <= 1'b1;
						pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;
endmodule

// ===== src/ecsr_checker.sv =====
// ----------------------------------------------------------------------------
// ecsr_checker
// Port-level checks (module ecsr_sva) for the compressed-row builder, bound to the top level.
// ----------------------------------------------------------------------------
module ecsr_sva #(
	parameter int MAX_EDGES = 4096
) (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ecsr_pkg::rsp_t rsp
);
	import ecsr_pkg::*;

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("input ready right after an accepted item");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.value == 14'd0)
		else $error("nonzero value on error status");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> rsp.legal_edges == 13'(MAX_EDGES))
		else $error("store full reported below capacity");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_NOTB)
		else $error("status code out of range");
endmodule

bind edge_list_to_csr_builder ecsr_sva #(.MAX_EDGES(MAX_EDGES)) u_ecsr_sva (
	.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
